// ===== rtl/core/ccts_pkg.sv =====
// Shared types and constants for the cycle counter timebase splitter.
package ccts_pkg;

    localparam int IN_W = 32;
    localparam int WRAP_W = 32;
    localparam int COUNT_W = 64;
    localparam int MHZ_W = 10;
    localparam int SECS_W = 45;
    localparam int PART_W = 10;
    localparam int REM_W = 20;
    localparam int CNT_W = 7;
    localparam int SAMPLE_WIDTH_DEF = 32;

    localparam logic [MHZ_W-1:0] CLOCK_RESET = 10'd168;
    localparam logic [MHZ_W-1:0] MHZ_MIN = 10'd1;
    localparam logic [REM_W-1:0] US_PER_S = 20'd1000000;
    localparam logic [REM_W-1:0] US_PER_MS = 20'd1000;
    localparam logic [CNT_W-1:0] CLOCK_STEP_LAST = 7'd64;
    localparam logic [CNT_W-1:0] MS_STEP_LAST = 7'd9;

    typedef struct packed {
        logic start;
        logic taken;
    } ccts_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ccts_status_t;

    typedef struct packed {
        logic [COUNT_W-1:0] total;
        logic [SECS_W-1:0]  secs;
        logic [PART_W-1:0]  ms;
        logic [PART_W-1:0]  us;
    } ccts_result_t;

endpackage

// ===== rtl/core/ccts_step_unit.sv =====
// Shared restoring-division step: one quotient bit per lane per cycle.
module ccts_step_unit (
    input  logic [ccts_pkg::MHZ_W-1:0] ra_i,
    input  logic                       a_bit_i,
    input  logic [ccts_pkg::MHZ_W-1:0] div_a_i,
    output logic [ccts_pkg::MHZ_W-1:0] ra_o,
    output logic                       qa_o,
    input  logic [ccts_pkg::REM_W-1:0] rb_i,
    input  logic                       b_bit_i,
    input  logic [ccts_pkg::REM_W-1:0] div_b_i,
    output logic [ccts_pkg::REM_W-1:0] rb_o,
    output logic                       qb_o
);

    logic [ccts_pkg::MHZ_W:0] ta;
    logic [ccts_pkg::MHZ_W:0] da;
    logic [ccts_pkg::REM_W:0] tb;
    logic [ccts_pkg::REM_W:0] db;

    always_comb begin
        ta = {ra_i, a_bit_i};
        da = {1'b0, div_a_i};
        qa_o = (ta >= da);
        ra_o = qa_o ? ccts_pkg::MHZ_W'(ta - da) : ta[ccts_pkg::MHZ_W-1:0];

        tb = {rb_i, b_bit_i};
        db = {1'b0, div_b_i};
        qb_o = (tb >= db);
        rb_o = qb_o ? ccts_pkg::REM_W'(tb - db) : tb[ccts_pkg::REM_W-1:0];
    end

endmodule

// ===== rtl/core/ccts_div_seq.sv =====
// Sequencer that drives the shared step unit to split a cycle count into time units.
module ccts_div_seq (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ccts_pkg::ccts_ctrl_t         ctrl_i,
    input  logic [ccts_pkg::COUNT_W-1:0] count_i,
    input  logic [ccts_pkg::MHZ_W-1:0]   mhz_i,
    output ccts_pkg::ccts_status_t       status_o,
    output ccts_pkg::ccts_result_t       result_o
);

    typedef enum logic [1:0] {
        IDLE,
        RUN_CLOCK,
        RUN_MS,
        FINISH
    } state_t;

    state_t                        state_reg, state_next;
    logic [ccts_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ccts_pkg::COUNT_W-1:0]  dq_reg, dq_next;
    logic [ccts_pkg::MHZ_W-1:0]    ra_reg, ra_next;
    logic                          qa_reg, qa_next;
    logic [ccts_pkg::REM_W-1:0]    rb_reg, rb_next;
    logic [ccts_pkg::SECS_W-1:0]   secs_reg, secs_next;
    logic [ccts_pkg::PART_W-1:0]   lo_reg, lo_next;
    logic [ccts_pkg::PART_W-1:0]   ms_reg, ms_next;

    logic                          b_bit;
    logic [ccts_pkg::REM_W-1:0]    div_b;
    logic [ccts_pkg::MHZ_W-1:0]    ra_step;
    logic                          qa_step;
    logic [ccts_pkg::REM_W-1:0]    rb_step;
    logic                          qb_step;

    ccts_step_unit u_step (
        .ra_i    (ra_reg),
        .a_bit_i (dq_reg[ccts_pkg::COUNT_W-1]),
        .div_a_i (mhz_i),
        .ra_o    (ra_step),
        .qa_o    (qa_step),
        .rb_i    (rb_reg),
        .b_bit_i (b_bit),
        .div_b_i (div_b),
        .rb_o    (rb_step),
        .qb_o    (qb_step)
    );

    always_comb begin
        b_bit = (state_reg == RUN_MS) ? lo_reg[ccts_pkg::PART_W-1] : qa_reg;
        div_b = (state_reg == RUN_MS) ? ccts_pkg::US_PER_MS : ccts_pkg::US_PER_S;

        state_next = state_reg;
        cnt_next   = cnt_reg;
        dq_next    = dq_reg;
        ra_next    = ra_reg;
        qa_next    = qa_reg;
        rb_next    = rb_reg;
        secs_next  = secs_reg;
        lo_next    = lo_reg;
        ms_next    = ms_reg;

        case (state_reg)
            IDLE: begin
                if (ctrl_i.start) begin
                    dq_next    = count_i;
                    ra_next    = '0;
                    qa_next    = 1'b0;
                    rb_next    = '0;
                    cnt_next   = '0;
                    state_next = RUN_CLOCK;
                end
            end
            RUN_CLOCK: begin
                // The microsecond quotient bits feed the seconds lane via qa_reg.
                if (cnt_reg != ccts_pkg::CLOCK_STEP_LAST) begin
                    dq_next = {dq_reg[ccts_pkg::COUNT_W-2:0], qa_step};
                    ra_next = ra_step;
                    qa_next = qa_step;
                end
                if (cnt_reg != '0) begin
                    rb_next   = rb_step;
                    secs_next = {secs_reg[ccts_pkg::SECS_W-2:0], qb_step};
                end
                if (cnt_reg == ccts_pkg::CLOCK_STEP_LAST) begin
                    rb_next    = ccts_pkg::REM_W'(rb_step >> ccts_pkg::PART_W);
                    lo_next    = rb_step[ccts_pkg::PART_W-1:0];
                    cnt_next   = '0;
                    state_next = RUN_MS;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            RUN_MS: begin
                rb_next = rb_step;
                ms_next = {ms_reg[ccts_pkg::PART_W-2:0], qb_step};
                lo_next = {lo_reg[ccts_pkg::PART_W-2:0], 1'b0};
                if (cnt_reg == ccts_pkg::MS_STEP_LAST) begin
                    state_next = FINISH;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            FINISH: begin
                if (ctrl_i.taken) begin
                    state_next = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg  <= cnt_next;
        dq_reg   <= dq_next;
        ra_reg   <= ra_next;
        qa_reg   <= qa_next;
        rb_reg   <= rb_next;
        secs_reg <= secs_next;
        lo_reg   <= lo_next;
        ms_reg   <= ms_next;
    end

    assign status_o.busy  = (state_reg != IDLE);
    assign status_o.done  = (state_reg == FINISH);
    assign result_o.total = dq_reg;
    assign result_o.secs  = secs_reg;
    assign result_o.ms    = ms_reg;
    assign result_o.us    = rb_reg[ccts_pkg::PART_W-1:0];

endmodule

// ===== rtl/core/cycle_counter_timebase_split_top.sv =====
// Top level of the cycle counter timebase splitter: wrap tracking, clock register and handshakes.
//
// Each accepted beat is one counter sample; the block extends it with a 32-bit wrap count to a
// 64-bit cycle count and returns that count together with whole seconds, milliseconds,
// microseconds and total microseconds for the programmed clock in MHz (zero is taken as 1 MHz).
// A new beat is accepted only while the block is idle, which it is again from the cycle in which
// the result of the last beat becomes valid. The work runs as bit-serial division of the 64-bit
// count by the clock, with the split by one million running one bit behind in the same shared
// step unit, then the millisecond split, and then the hand-off of the result to the output
// register. The result waits in that output register, so a slow consumer stalls the block only
// when a second result is finished before the first was taken.
module cycle_counter_timebase_split_top #(
    parameter int SAMPLE_WIDTH = ccts_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [ccts_pkg::MHZ_W-1:0]   cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ccts_pkg::IN_W-1:0]    s_counter_sample,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ccts_pkg::COUNT_W-1:0] m_extended_count,
    output logic [ccts_pkg::SECS_W-1:0]  m_whole_seconds,
    output logic [ccts_pkg::PART_W-1:0]  m_milliseconds_part,
    output logic [ccts_pkg::PART_W-1:0]  m_microseconds_part,
    output logic [ccts_pkg::COUNT_W-1:0] m_total_microseconds
);

    logic [ccts_pkg::MHZ_W-1:0]    clock_mhz_reg;
    logic [ccts_pkg::MHZ_W-1:0]    mhz_eff;
    logic [ccts_pkg::WRAP_W-1:0]   wrap_count_reg, wrap_count_next;
    logic [SAMPLE_WIDTH-1:0]       prev_sample_reg;
    logic [SAMPLE_WIDTH-1:0]       sample;
    logic [ccts_pkg::COUNT_W-1:0]  count;
    logic [ccts_pkg::COUNT_W-1:0]  count_reg;
    logic                          accept;
    logic                          load;
    logic                          m_valid_reg;
    logic [ccts_pkg::COUNT_W-1:0]  ext_out_reg;
    ccts_pkg::ccts_result_t        res_out_reg;
    ccts_pkg::ccts_ctrl_t          ctrl;
    ccts_pkg::ccts_status_t        status;
    ccts_pkg::ccts_result_t        result;

    assign sample  = s_counter_sample[SAMPLE_WIDTH-1:0];
    assign mhz_eff = (clock_mhz_reg == '0) ? ccts_pkg::MHZ_MIN : clock_mhz_reg;
    assign s_ready = !status.busy;
    assign accept  = s_valid && s_ready;
    assign load    = status.done && (!m_valid_reg || m_ready);

    assign wrap_count_next = (sample < prev_sample_reg) ? wrap_count_reg + 1'b1 : wrap_count_reg;
    assign count = (ccts_pkg::COUNT_W'(wrap_count_next) << SAMPLE_WIDTH)
                 | ccts_pkg::COUNT_W'(sample);

    assign ctrl.start = accept;
    assign ctrl.taken = load;

    ccts_div_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl_i   (ctrl),
        .count_i  (count),
        .mhz_i    (mhz_eff),
        .status_o (status),
        .result_o (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_mhz_reg   <= ccts_pkg::CLOCK_RESET;
            wrap_count_reg  <= '0;
            prev_sample_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                clock_mhz_reg <= cfg_wdata;
            end
            if (accept) begin
                wrap_count_reg  <= wrap_count_next;
                prev_sample_reg <= sample;
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            count_reg <= count;
        end
        if (load) begin
            ext_out_reg <= count_reg;
            res_out_reg <= result;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_extended_count     = ext_out_reg;
    assign m_whole_seconds      = res_out_reg.secs;
    assign m_milliseconds_part  = res_out_reg.ms;
    assign m_microseconds_part  = res_out_reg.us;
    assign m_total_microseconds = res_out_reg.total;

    a_parts_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_milliseconds_part < 10'd1000) && (m_microseconds_part < 10'd1000))
        else $error("Millisecond or microsecond part out of range.");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("Block still ready after taking a beat.");

    a_wrap_step: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (wrap_count_reg == $past(wrap_count_reg))
              || (wrap_count_reg == $past(wrap_count_reg) + 32'd1))
        else $error("Wrap count moved by more than one.");

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> status.done && (!m_valid || m_ready))
        else $error("Result loaded over one not yet taken.");

endmodule

// ===== bench/tb_cycle_counter_timebase_split_top.sv =====
// Self-checking testbench for the cycle counter timebase splitter top level.
module tb_cycle_counter_timebase_split_top;

    typedef struct {
        logic [ccts_pkg::COUNT_W-1:0] count;
        logic [ccts_pkg::SECS_W-1:0]  secs;
        logic [ccts_pkg::PART_W-1:0]  ms;
        logic [ccts_pkg::PART_W-1:0]  us;
        logic [ccts_pkg::COUNT_W-1:0] total;
    } split_t;

    localparam int SW = ccts_pkg::SAMPLE_WIDTH_DEF;
    localparam int HOLD_OFF_CYCLES = 400;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [ccts_pkg::MHZ_W-1:0]   cfg_wdata = '0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [ccts_pkg::IN_W-1:0]    s_counter_sample = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [ccts_pkg::COUNT_W-1:0] m_extended_count;
    logic [ccts_pkg::SECS_W-1:0]  m_whole_seconds;
    logic [ccts_pkg::PART_W-1:0]  m_milliseconds_part;
    logic [ccts_pkg::PART_W-1:0]  m_microseconds_part;
    logic [ccts_pkg::COUNT_W-1:0] m_total_microseconds;

    logic [ccts_pkg::MHZ_W-1:0]   mhz_setting = ccts_pkg::CLOCK_RESET;
    logic [ccts_pkg::WRAP_W-1:0]  wrap_total = '0;
    logic [ccts_pkg::IN_W-1:0]    last_sample = '0;

    split_t expected_splits[$];
    split_t want;

    bit gaps_on = 1'b0;
    bit stalls_on = 1'b0;
    int hold_cycles = 0;
    int mismatches = 0;
    int samples_sent = 0;
    int results_seen = 0;
    int wraps_seen = 0;
    int clocks_set = 0;

    cycle_counter_timebase_split_top dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_we),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_counter_sample     (s_counter_sample),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_extended_count     (m_extended_count),
        .m_whole_seconds      (m_whole_seconds),
        .m_milliseconds_part  (m_milliseconds_part),
        .m_microseconds_part  (m_microseconds_part),
        .m_total_microseconds (m_total_microseconds)
    );

    always #2 aclk = ~aclk;

    // A zero clock setting counts as 1 MHz.
    function automatic split_t predict_split(input logic [ccts_pkg::IN_W-1:0] raw);
        split_t r;
        logic [63:0] sample, mhz, per_s, per_ms, count, secs, rest, ms, us;
        sample = 64'(raw) & ((64'd1 << SW) - 64'd1);
        mhz = (mhz_setting == '0) ? 64'd1 : 64'(mhz_setting);
        per_s = mhz * 64'd1000000;
        per_ms = mhz * 64'd1000;
        if (sample < 64'(last_sample)) begin
            wrap_total = wrap_total + 1'b1;
            wraps_seen++;
        end
        last_sample = ccts_pkg::IN_W'(sample);
        count = (64'(wrap_total) << SW) + sample;
        secs = count / per_s;
        rest = count - secs * per_s;
        ms = rest / per_ms;
        rest = rest - ms * per_ms;
        us = rest / mhz;
        r.count = count;
        r.secs = ccts_pkg::SECS_W'(secs);
        r.ms = ccts_pkg::PART_W'(ms);
        r.us = ccts_pkg::PART_W'(us);
        r.total = secs * 64'd1000000 + ms * 64'd1000 + us;
        return r;
    endfunction

    task automatic send_sample(input logic [ccts_pkg::IN_W-1:0] value);
        int gap;
        @(negedge aclk);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_counter_sample <= value;
        do @(posedge aclk); while (!s_ready);
        expected_splits.push_back(predict_split(value));
        samples_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_splits.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_clock(input logic [ccts_pkg::MHZ_W-1:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        mhz_setting = value;
        clocks_set++;
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH beat %0d %s: expected %0d, got %0d",
                         results_seen, name, exp_v, got_v);
        end
    endtask

    task automatic test_directed_samples();
        send_sample(32'h0000_0000);
        send_sample(32'h0000_0000);
        send_sample(32'h0000_0001);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h5555_5555);
        send_sample(32'hAAAA_AAAA);
        send_sample(32'h0000_0005);
        send_sample(32'd168);
        send_sample(32'd167_999_999);
        send_sample(32'd168_000_000);
    endtask

    // Zero, the range ends and values above the nominal range.
    task automatic test_clock_extremes();
        logic [ccts_pkg::MHZ_W-1:0] settings[5] = '{10'd0, 10'd1, 10'd1000, 10'd1023, 10'd1001};
        foreach (settings[i]) begin
            write_clock(settings[i]);
            send_sample(32'd999_999);
            send_sample(32'hFFFF_FFFE);
        end
    endtask

    // Mostly a counter running forward by random steps, with wraps, repeats and noise.
    task automatic test_random_counts();
        logic [ccts_pkg::MHZ_W-1:0] settings[8];
        logic [ccts_pkg::IN_W-1:0] cur;
        int pick;
        settings = '{10'd1, 10'd1023, ccts_pkg::MHZ_W'($urandom_range(0, 1023)), 10'd1000,
                     10'd0, ccts_pkg::MHZ_W'($urandom_range(1, 1000)),
                     ccts_pkg::MHZ_W'($urandom_range(0, 1023)), ccts_pkg::CLOCK_RESET};
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        cur = last_sample;
        foreach (settings[p]) begin
            write_clock(settings[p]);
            repeat (80) begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    cur = cur + $urandom_range(1, 32'd1 << $urandom_range(0, 31));
                else if (pick < 75)
                    cur = (cur == '0) ? $urandom : $urandom_range(0, cur - 1);
                else if (pick >= 85)
                    cur = $urandom;
                send_sample(cur);
            end
        end
    endtask

    task automatic test_receiver_hold_off();
        drain();
        gaps_on = 1'b0;
        hold_cycles = HOLD_OFF_CYCLES;
        repeat (20) send_sample($urandom);
    endtask

    task automatic test_full_rate();
        write_clock(ccts_pkg::MHZ_W'($urandom_range(1, 1023)));
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        repeat (50) send_sample($urandom);
    endtask

    initial begin : ready_driver
        int burst;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else if (stalls_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 7);
                m_ready <= 1'b0;
                repeat (burst - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_splits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("MISMATCH unexpected result beat, count %0d", m_extended_count);
            end else begin
                want = expected_splits.pop_front();
                check_field("extended_count", want.count, m_extended_count);
                check_field("whole_seconds", 64'(want.secs), 64'(m_whole_seconds));
                check_field("milliseconds_part", 64'(want.ms), 64'(m_milliseconds_part));
                check_field("microseconds_part", 64'(want.us), 64'(m_microseconds_part));
                check_field("total_microseconds", want.total, m_total_microseconds);
            end
            results_seen++;
        end
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d results still outstanding.", expected_splits.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_samples();
        test_clock_extremes();
        test_random_counts();
        test_receiver_hold_off();
        test_full_rate();
        drain();
        repeat (80) @(posedge aclk);
        $display("Sent %0d samples across %0d clock settings with %0d counter wraps,",
                 samples_sent, clocks_set, wraps_seen);
        $display("including a %0d-cycle receiver hold-off; %0d results checked.",
                 HOLD_OFF_CYCLES, results_seen);
        if (mismatches == 0 && expected_splits.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
